// ===== hw/rtl/ffha_pkg.sv =====
package ffha_pkg;

    // Table geometry
    localparam int MAX_SEGMENTS = 64;
    localparam int SEG_IDX_W    = $clog2(MAX_SEGMENTS);
    localparam int SEG_CNT_W    = $clog2(MAX_SEGMENTS + 1);

    // Header sizes in bytes
    localparam int BLOCK_HEADER_BYTES  = 12;
    localparam int REGION_HEADER_BYTES = 8;

    // Field widths
    localparam int ADDR_W = 32;
    localparam int SIZE_W = 24;
    localparam int NEED_W = SIZE_W + 1;
    localparam int ENTRY_W = SIZE_W + 1;

    // Result codes
    localparam logic [1:0] STATUS_DONE     = 2'd0;
    localparam logic [1:0] STATUS_NO_FIT   = 2'd1;
    localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

    // Request modes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Register indexes
    localparam logic CFG_BASE_ADDRESS = 1'b0;
    localparam logic CFG_REGION_SIZE  = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic start;
        logic scan;
        logic split;
        logic flush;
        logic finish;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic split_det;
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

// ===== hw/rtl/ffha_ram.sv =====
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/ffha_ctrl.sv =====
module ffha_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  ffha_pkg::t_sts  i_sts,
    output ffha_pkg::t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_SPLIT  = 5'b00100,
        S_FLUSH  = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.split_det) begin
                    n_state = S_SPLIT;
                end else if (i_sts.scan_done) begin
                    n_state = S_FLUSH;
                end
            end
            S_SPLIT: begin
                o_cmd.split = 1'b1;
                n_state     = S_SCAN;
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state     = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/ffha_dp.sv =====
module ffha_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ffha_pkg::t_cmd                i_cmd,
    output ffha_pkg::t_sts                o_sts,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [ffha_pkg::ADDR_W-1:0]   i_cfg_data,
    input  logic                          i_mode,
    input  logic [ffha_pkg::SIZE_W-1:0]   i_request_size,
    input  logic [ffha_pkg::ADDR_W-1:0]   i_free_address,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_status,
    output logic [ffha_pkg::ADDR_W-1:0]   o_data_address
);

    localparam int AW = ffha_pkg::ADDR_W;
    localparam int SW = ffha_pkg::SIZE_W;
    localparam int NW = ffha_pkg::NEED_W;
    localparam int CW = ffha_pkg::SEG_CNT_W;
    localparam int IW = ffha_pkg::SEG_IDX_W;
    localparam int EW = ffha_pkg::ENTRY_W;

    // Configuration and table bookkeeping
    logic [AW-1:0] r_base;
    logic [SW-1:0] r_region;
    logic          r_fresh;
    logic          r_bank;
    logic [CW-1:0] r_count;

    // Request context
    logic          r_mode;
    logic [NW-1:0] r_need;
    logic [AW-1:0] r_faddr;
    logic [AW-1:0] r_hdr;
    logic [AW-1:0] r_addr;
    logic          r_done;
    logic          r_ok;
    logic [SW-1:0] r_rem;

    // Scan pointers
    logic [CW-1:0] r_ridx;
    logic [CW-1:0] r_wcnt;
    logic          r_pv;
    logic          r_p0;

    // Pending output entry (coalescing stage)
    logic          r_pend_v;
    logic [SW-1:0] r_pend_size;
    logic          r_pend_free;

    logic [EW-1:0] q0;
    logic [EW-1:0] q1;
    logic [EW-1:0] q;

    logic [CW-1:0] eff_count;
    logic [SW-1:0] cur_size;
    logic          cur_free;
    logic          fits;
    logic          exact;
    logic          full;
    logic          match_alloc;
    logic          match_free;
    logic          proc;
    logic          issue;
    logic          emit;
    logic [SW-1:0] e_size;
    logic          e_free;
    logic          merge;
    logic          we;
    logic [NW+1:0] need_raw;
    logic [AW-1:0] data_ptr;
    logic          region_ok;

    assign region_ok = {8'd0, r_region} >=
        AW'(ffha_pkg::REGION_HEADER_BYTES + ffha_pkg::BLOCK_HEADER_BYTES);
    assign eff_count = r_fresh ? (region_ok ? CW'(1) : CW'(0)) : r_count;

    assign q = r_bank ? q1 : q0;

    // Current entry; a fresh table reads entry 0 as the whole region
    always_comb begin
        if (r_p0 && r_fresh) begin
            cur_size = r_region - SW'(ffha_pkg::REGION_HEADER_BYTES);
            cur_free = 1'b1;
        end else begin
            cur_size = q[SW-1:0];
            cur_free = q[SW];
        end
    end

    assign data_ptr    = r_hdr + AW'(ffha_pkg::BLOCK_HEADER_BYTES);
    assign proc        = i_cmd.scan && r_pv;
    assign fits        = cur_free && ({1'b0, cur_size} >= r_need);
    assign exact       = ({1'b0, cur_size} == r_need);
    assign full        = (r_count >= CW'(ffha_pkg::MAX_SEGMENTS)) && !r_fresh;
    assign match_alloc = proc && (r_mode == ffha_pkg::MODE_ALLOC) && !r_done && fits;
    assign match_free  = proc && (r_mode == ffha_pkg::MODE_FREE) && !r_done &&
                         !cur_free && (data_ptr == r_faddr);

    assign o_sts.split_det = match_alloc && !exact && !full;
    assign o_sts.scan_done = i_cmd.scan && !r_pv && (r_ridx >= eff_count);
    assign o_sts.out_free  = !o_out_valid || i_out_ready;

    assign issue = ((i_cmd.scan && !o_sts.split_det) || i_cmd.split) &&
                   (r_ridx < eff_count);

    // Entry handed to the coalescing stage
    always_comb begin
        emit   = proc || i_cmd.split;
        e_size = cur_size;
        e_free = cur_free;
        if (i_cmd.split) begin
            e_size = r_rem;
            e_free = 1'b1;
        end else if (match_alloc && !(full && !exact)) begin
            e_size = r_need[SW-1:0];
            e_free = 1'b0;
        end else if (match_free) begin
            e_free = 1'b1;
        end
    end

    assign merge = emit && r_pend_v && r_pend_free && e_free;
    assign we    = ((emit && !merge) || i_cmd.flush) && r_pend_v;

    assign need_raw = (NW+2)'(i_request_size) +
                      (NW+2)'(ffha_pkg::BLOCK_HEADER_BYTES + 3);

    // Table banks: read the current one, build the next one
    ffha_ram #(.WIDTH(EW), .DEPTH(ffha_pkg::MAX_SEGMENTS)) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (we && r_bank),
        .i_waddr (r_wcnt[IW-1:0]),
        .i_wdata ({r_pend_free, r_pend_size}),
        .i_re    (issue),
        .i_raddr (r_ridx[IW-1:0]),
        .o_rdata (q0)
    );

    ffha_ram #(.WIDTH(EW), .DEPTH(ffha_pkg::MAX_SEGMENTS)) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (we && !r_bank),
        .i_waddr (r_wcnt[IW-1:0]),
        .i_wdata ({r_pend_free, r_pend_size}),
        .i_re    (issue),
        .i_raddr (r_ridx[IW-1:0]),
        .o_rdata (q1)
    );

    // Request context and scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_mode  <= i_mode;
            r_need  <= {need_raw[NW-1:2], 2'b00};
            r_faddr <= i_free_address;
            r_hdr   <= r_base + AW'(ffha_pkg::REGION_HEADER_BYTES);
            r_done  <= 1'b0;
            r_ok    <= 1'b0;
            r_ridx  <= '0;
            r_wcnt  <= '0;
            r_pv    <= 1'b0;
            r_p0    <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            if (i_cmd.scan || i_cmd.split) begin
                r_pv <= issue;
                r_p0 <= (r_ridx == '0);
                if (issue) begin
                    r_ridx <= r_ridx + CW'(1);
                end
            end
            if (proc) begin
                r_hdr <= r_hdr + AW'(cur_size);
            end
            if (match_alloc) begin
                r_done <= 1'b1;
                r_rem  <= cur_size - r_need[SW-1:0];
                if (exact || !full) begin
                    r_ok   <= 1'b1;
                    r_addr <= data_ptr;
                end
            end
            if (match_free) begin
                r_done <= 1'b1;
                r_ok   <= 1'b1;
            end
            if (we) begin
                r_wcnt <= r_wcnt + CW'(1);
            end
            if (merge) begin
                r_pend_size <= r_pend_size + e_size;
            end else if (emit) begin
                r_pend_v    <= 1'b1;
                r_pend_size <= e_size;
                r_pend_free <= e_free;
            end else if (i_cmd.flush) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    // Configuration, bank swap and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_region    <= SW'(65536);
            r_fresh     <= 1'b1;
            r_bank      <= 1'b0;
            r_count     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    ffha_pkg::CFG_BASE_ADDRESS: r_base <= i_cfg_data;
                    ffha_pkg::CFG_REGION_SIZE:  r_region <= i_cfg_data[SW-1:0];
                    default: ;
                endcase
                r_fresh <= 1'b1;
            end
            if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            if (i_cmd.finish) begin
                o_out_valid <= 1'b1;
                if (r_ok) begin
                    r_bank  <= !r_bank;
                    r_count <= r_wcnt;
                    r_fresh <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (r_ok) begin
                o_status <= ffha_pkg::STATUS_DONE;
            end else if (r_mode == ffha_pkg::MODE_ALLOC) begin
                o_status <= ffha_pkg::STATUS_NO_FIT;
            end else begin
                o_status <= ffha_pkg::STATUS_BAD_FREE;
            end
            o_data_address <= (r_ok && r_mode == ffha_pkg::MODE_ALLOC) ? r_addr : '0;
        end
    end

endmodule

// ===== hw/rtl/first_fit_heap_allocator.sv =====
// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_ready    i_mode, i_request_size, i_free_address
// out       output     o_out_valid / i_out_ready  o_status, o_data_address
// cfg       input      i_cfg_we                   i_cfg_index, i_cfg_data
//
// One request at a time for a table of N segments (N up to 64); the scan reads one
// table entry per cycle, pausing while a split is inserted, from a single RAM read
// port and writes the rebuilt table into the other bank.
// Synchronous active-low reset; no clearing pass, the table starts as one segment.
// A result waiting on o_out_valid does not block the next item being accepted.
module first_fit_heap_allocator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [ffha_pkg::ADDR_W-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_mode,
    input  logic [ffha_pkg::SIZE_W-1:0] i_request_size,
    input  logic [ffha_pkg::ADDR_W-1:0] i_free_address,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [1:0]                  o_status,
    output logic [ffha_pkg::ADDR_W-1:0] o_data_address
);

    ffha_pkg::t_cmd cmd;
    ffha_pkg::t_sts sts;

    ffha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ffha_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_mode         (i_mode),
        .i_request_size (i_request_size),
        .i_free_address (i_free_address),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_data_address (o_data_address)
    );

endmodule

// ===== tb/sv/tb.sv =====
module tb;
    import ffha_pkg::*;

    // Expected result of one item
    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] data_address;
    } t_alloc_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic               i_cfg_index;
    logic [ADDR_W-1:0]  i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_mode;
    logic [SIZE_W-1:0]  i_request_size;
    logic [ADDR_W-1:0]  i_free_address;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [1:0]         o_status;
    logic [ADDR_W-1:0]  o_data_address;

    first_fit_heap_allocator u_top (.*);

    // Shadow copy of the segment table
    logic [31:0]        heap_base;
    logic [31:0]        heap_region;
    logic [SIZE_W-1:0]  shadow_size [MAX_SEGMENTS];
    bit                 shadow_free [MAX_SEGMENTS];
    int                 shadow_count;

    t_alloc_result      pending_results[$];
    logic [31:0]        live_blocks[$];
    int                 err_cnt;
    bit                 hold_req;
    bit                 no_idle;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #8000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Table rebuild after reset or a register write
    function automatic void rebuild_heap();
        for (int k = 0; k < MAX_SEGMENTS; k++) begin
            shadow_size[k] = '0;
            shadow_free[k] = 1'b0;
        end
        live_blocks.delete();
        if (heap_region < REGION_HEADER_BYTES + BLOCK_HEADER_BYTES) begin
            shadow_count = 0;
        end else begin
            shadow_count = 1;
            shadow_size[0] = SIZE_W'(heap_region - REGION_HEADER_BYTES);
            shadow_free[0] = 1'b1;
        end
    endfunction

    // Merge neighboring free segments
    function automatic void merge_free();
        int w;
        w = 0;
        for (int r = 0; r < shadow_count; r++) begin
            if (w > 0 && shadow_free[w-1] && shadow_free[r]) begin
                shadow_size[w-1] = shadow_size[w-1] + shadow_size[r];
            end else begin
                shadow_size[w] = shadow_size[r];
                shadow_free[w] = shadow_free[r];
                w++;
            end
        end
        for (int r = w; r < MAX_SEGMENTS; r++) begin
            shadow_size[r] = '0;
            shadow_free[r] = 1'b0;
        end
        shadow_count = w;
    endfunction

    // First-fit allocate or release on the shadow table
    function automatic t_alloc_result heap_outcome(logic mode, logic [SIZE_W-1:0] req,
                                                   logic [31:0] faddr);
        t_alloc_result res;
        logic [31:0]   need;
        logic [31:0]   hdr;
        logic [31:0]   rem;
        bit            found;
        res.status = (mode == MODE_ALLOC) ? STATUS_NO_FIT : STATUS_BAD_FREE;
        res.data_address = '0;
        hdr = heap_base + REGION_HEADER_BYTES;
        found = 1'b0;
        if (mode == MODE_ALLOC) begin
            need = ({8'd0, req} + BLOCK_HEADER_BYTES + 3) & ~32'd3;
            for (int i = 0; i < shadow_count && !found; i++) begin
                if (shadow_free[i] && {8'd0, shadow_size[i]} >= need) begin
                    found = 1'b1;
                    rem = {8'd0, shadow_size[i]} - need;
                    if (rem == 0 || shadow_count < MAX_SEGMENTS) begin
                        if (rem != 0) begin
                            for (int j = shadow_count; j > i + 1; j--) begin
                                shadow_size[j] = shadow_size[j-1];
                                shadow_free[j] = shadow_free[j-1];
                            end
                            shadow_size[i+1] = SIZE_W'(rem);
                            shadow_free[i+1] = 1'b1;
                            shadow_count++;
                        end
                        shadow_size[i] = SIZE_W'(need);
                        shadow_free[i] = 1'b0;
                        res.status = STATUS_DONE;
                        res.data_address = hdr + BLOCK_HEADER_BYTES;
                        live_blocks.push_back(res.data_address);
                    end
                end
                hdr = hdr + shadow_size[i];
            end
        end else begin
            for (int i = 0; i < shadow_count && !found; i++) begin
                if (!shadow_free[i] && hdr + BLOCK_HEADER_BYTES == faddr) begin
                    found = 1'b1;
                    shadow_free[i] = 1'b1;
                    res.status = STATUS_DONE;
                    foreach (live_blocks[k]) if (live_blocks[k] == faddr) begin
                        live_blocks.delete(k);
                        break;
                    end
                end
                hdr = hdr + shadow_size[i];
            end
        end
        merge_free();
        return res;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one item and wait for it to be taken
    task automatic send_request(logic mode, logic [SIZE_W-1:0] req, logic [31:0] faddr);
        int gap;
        i_in_valid     <= 1'b1;
        i_mode         <= mode;
        i_request_size <= req;
        i_free_address <= faddr;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(heap_outcome(mode, req, faddr));
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drain, then write one register
    task automatic write_reg(logic idx, logic [31:0] value);
        if (i_in_valid) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_BASE_ADDRESS) heap_base = value;
        else heap_region = {8'd0, value[SIZE_W-1:0]};
        rebuild_heap();
    endtask

    // Result checker and receiver stalls
    initial begin
        t_alloc_result exp_res;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result with nothing pending: status %0d addr %h",
                           o_status, o_data_address);
                    err_cnt++;
                end else begin
                    exp_res = pending_results.pop_front();
                    if (o_status !== exp_res.status) begin
                        $error("status: expected %0d, got %0d", exp_res.status, o_status);
                        err_cnt++;
                    end
                    if (o_data_address !== exp_res.data_address) begin
                        $error("data_address: expected %h, got %h",
                               exp_res.data_address, o_data_address);
                        err_cnt++;
                    end
                end
            end
            if (hold_req) begin
                i_out_ready <= 1'b0;
                for (int c = 0; c < 400; c++) @(posedge i_clk);
                hold_req = 1'b0;
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= (no_idle || $urandom_range(0, 3) != 0);
            end
        end
    end

    // Extremes, exact fit, bad frees
    task automatic test_directed_basic();
        logic [31:0] a0;
        send_request(MODE_ALLOC, 24'd0, '0);
        a0 = live_blocks[$];
        send_request(MODE_ALLOC, 24'd5, '0);
        send_request(MODE_ALLOC, 24'hFFFFFF, '0);
        send_request(MODE_FREE, '0, a0 + 1);
        send_request(MODE_FREE, '0, 32'hFFFFFFFF);
        send_request(MODE_FREE, '0, a0);
        send_request(MODE_FREE, '0, a0);
        send_request(MODE_ALLOC, 24'd65516, '0);
        send_request(MODE_FREE, '0, live_blocks[0]);
        send_request(MODE_ALLOC, 24'd65517, '0);
        send_request(MODE_ALLOC, 24'd65516, '0);
    endtask

    // Fill the table with small blocks until a split no longer fits
    task automatic test_table_full();
        write_reg(CFG_BASE_ADDRESS, 32'h0000_1000);
        write_reg(CFG_REGION_SIZE, 32'd65536);
        for (int k = 0; k < 65; k++) send_request(MODE_ALLOC, 24'd0, '0);
        send_request(MODE_FREE, '0, live_blocks[3]);
        send_request(MODE_ALLOC, 24'd1, '0);
    endtask

    // Addresses wrapping past the top, and degenerate regions
    task automatic test_extreme_regions();
        write_reg(CFG_BASE_ADDRESS, 32'hFFFF_FFF0);
        write_reg(CFG_REGION_SIZE, 32'hFFFF_FFFF);
        send_request(MODE_ALLOC, 24'd3, '0);
        send_request(MODE_ALLOC, 24'd100, '0);
        send_request(MODE_FREE, '0, live_blocks[0]);
        write_reg(CFG_REGION_SIZE, 32'd20);
        send_request(MODE_ALLOC, 24'd1, '0);
        send_request(MODE_ALLOC, 24'd0, '0);
        send_request(MODE_FREE, '0, heap_base + 20);
        write_reg(CFG_REGION_SIZE, 32'd19);
        send_request(MODE_ALLOC, 24'd0, '0);
        send_request(MODE_FREE, '0, heap_base + 20);
    endtask

    // Random mix of allocations, valid frees and noise
    task automatic test_random_mix(int n_items);
        int          r;
        logic [31:0] pick;
        for (int k = 0; k < n_items; k++) begin
            r = $urandom_range(0, 99);
            if (k % 100 == 0) no_idle = ($urandom_range(0, 2) == 0);
            if (r < 45) begin
                send_request(MODE_ALLOC, ($urandom_range(0, 9) == 0) ?
                             SIZE_W'($urandom) : SIZE_W'($urandom_range(0, 300)),
                             $urandom);
            end else if (r < 85 && live_blocks.size() != 0) begin
                pick = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
                send_request(MODE_FREE, SIZE_W'($urandom), pick);
            end else if (r < 93 && live_blocks.size() != 0) begin
                pick = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
                send_request(MODE_FREE, '0, pick + $urandom_range(1, 16));
            end else begin
                send_request(MODE_FREE, '0, $urandom);
            end
        end
        no_idle = 1'b0;
    endtask

    // Long receiver stall while items keep coming
    task automatic test_backpressure();
        hold_req = 1'b1;
        no_idle  = 1'b1;
        for (int k = 0; k < 30; k++) send_request(MODE_ALLOC, SIZE_W'($urandom_range(0, 40)), '0);
        no_idle  = 1'b0;
    endtask

    initial begin
        err_cnt        = 0;
        hold_req       = 1'b0;
        no_idle        = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_BASE_ADDRESS;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_mode         = MODE_ALLOC;
        i_request_size = '0;
        i_free_address = '0;
        heap_base      = '0;
        heap_region    = 32'd65536;
        rebuild_heap();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_basic();
        test_table_full();
        test_extreme_regions();
        write_reg(CFG_BASE_ADDRESS, 32'd0);
        write_reg(CFG_REGION_SIZE, 32'd65536);
        test_backpressure();
        test_random_mix(320);
        write_reg(CFG_BASE_ADDRESS, $urandom);
        write_reg(CFG_REGION_SIZE, 32'd2000);
        test_random_mix(320);
        write_reg(CFG_BASE_ADDRESS, 32'hFFFF_FF00);
        write_reg(CFG_REGION_SIZE, 32'h00FF_FFFF);
        test_random_mix(320);
        write_reg(CFG_REGION_SIZE, 32'd300);
        test_random_mix(300);
        write_reg(CFG_BASE_ADDRESS, $urandom);
        write_reg(CFG_REGION_SIZE, $urandom_range(20, 24'hFFFFFF));
        test_random_mix(320);
        write_reg(CFG_REGION_SIZE, $urandom_range(500, 20000));
        test_random_mix(240);

        // drain and let the block settle
        if (i_in_valid) i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/ffha_pkg.sv
hw/rtl/ffha_ram.sv
hw/rtl/ffha_ctrl.sv
hw/rtl/ffha_dp.sv
hw/rtl/first_fit_heap_allocator.sv
tb/sv/tb.sv
